// ----- rtl/core/stt_pkg.sv -----
// Shared constants, token kinds and result types for the source text tokenizer.
package stt_pkg;

	// Counter widths; the position ports carry the low 16 bits.
	localparam int LINE_BITS   = 16;
	localparam int COLUMN_BITS = 16;
	localparam int POS_BITS    = 16;

	// Result queue between the scan stage and the output port.
	localparam int FIFO_DEPTH = 4;
	localparam int PTR_BITS   = $clog2(FIFO_DEPTH);
	localparam int CNT_BITS   = $clog2(FIFO_DEPTH + 1);

	// Token kinds.
	localparam logic [4:0] K_ID     = 5'd0;
	localparam logic [4:0] K_NUM    = 5'd1;
	localparam logic [4:0] K_STR    = 5'd2;
	localparam logic [4:0] K_POPEN  = 5'd3;
	localparam logic [4:0] K_PCLOSE = 5'd4;
	localparam logic [4:0] K_SOPEN  = 5'd5;
	localparam logic [4:0] K_SCLOSE = 5'd6;
	localparam logic [4:0] K_MINUS  = 5'd7;
	localparam logic [4:0] K_PLUS   = 5'd8;
	localparam logic [4:0] K_MUL    = 5'd9;
	localparam logic [4:0] K_DIV    = 5'd10;
	localparam logic [4:0] K_ARROW  = 5'd11;
	localparam logic [4:0] K_EQEQ   = 5'd12;
	localparam logic [4:0] K_NEQ    = 5'd13;
	localparam logic [4:0] K_NOT    = 5'd14;
	localparam logic [4:0] K_GE     = 5'd15;
	localparam logic [4:0] K_GT     = 5'd16;
	localparam logic [4:0] K_LE     = 5'd17;
	localparam logic [4:0] K_LT     = 5'd18;
	localparam logic [4:0] K_EOF    = 5'd19;

	// Character codes.
	localparam logic [7:0] CH_US     = 8'h5F;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_EQ     = 8'h3D;
	localparam logic [7:0] CH_BANG   = 8'h21;
	localparam logic [7:0] CH_GT     = 8'h3E;
	localparam logic [7:0] CH_LT     = 8'h3C;
	localparam logic [7:0] CH_POPEN  = 8'h28;
	localparam logic [7:0] CH_PCLOSE = 8'h29;
	localparam logic [7:0] CH_SOPEN  = 8'h5B;
	localparam logic [7:0] CH_SCLOSE = 8'h5D;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_Z = 8'h5A;
	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [7:0] CH_LOWER_Z = 8'h7A;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;

	// One result word without its position.
	typedef struct packed {
		logic [4:0] kind;
		logic       has;
		logic [7:0] text;
		logic       fin;
	} res_t;

	// One queued result word with the position at emission.
	typedef struct packed {
		res_t                res;
		logic [POS_BITS-1:0] line;
		logic [POS_BITS-1:0] col;
	} entry_t;

	// Closing or single-item token word.
	function automatic res_t op_res(input logic [4:0] kind);
		res_t r;
		r.kind = kind;
		r.has  = 1'b0;
		r.text = 8'h00;
		r.fin  = 1'b1;
		return r;
	endfunction

	// Text word carrying one character.
	function automatic res_t text_res(input logic [4:0] kind, input logic [7:0] b);
		res_t r;
		r.kind = kind;
		r.has  = 1'b1;
		r.text = b;
		r.fin  = 1'b0;
		return r;
	endfunction

	function automatic logic is_alpha(input logic [7:0] b);
		return (b inside {[CH_UPPER_A:CH_UPPER_Z], [CH_LOWER_A:CH_LOWER_Z]}) || (b == CH_US);
	endfunction

	function automatic logic is_digit(input logic [7:0] b);
		return b inside {[CH_ZERO:CH_NINE]};
	endfunction

endpackage

// ----- rtl/core/source_text_tokenizer.sv -----
// Source text tokenizer: scan stage, position counters and output result queue.
//
//  channel | handshake           | payload
//  --------+---------------------+-------------------------------------------------
//  in      | in_valid / in_stall | char_byte, end_of_input
//  out     | out_valid/out_stall | token_kind, has_byte, text_byte, token_end,
//          |                     | line_number, column_number
//
// One input word is accepted per cycle while in_stall is low; the scan stage handles
// it when the queue has room and pushes zero, one or two words into a four-entry queue.
// The output side drains one word per cycle while out_stall is low.
// A word's first result is offered once the scan stage has pushed it into the queue.
// Reset clears the scan mode, both counters and the queue; there is no clearing pass.
// Input stalls only while the queue has fewer than two free entries.
module source_text_tokenizer
	import stt_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [7:0]          char_byte,
	input  logic                end_of_input,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [4:0]          token_kind,
	output logic                has_byte,
	output logic [7:0]          text_byte,
	output logic                token_end,
	output logic [POS_BITS-1:0] line_number,
	output logic [POS_BITS-1:0] column_number
);

	typedef enum logic [3:0] {
		M_IDLE, M_ID, M_NUM, M_NUMDOT, M_STR, M_COMMENT,
		M_EQ, M_BANG, M_GT, M_LT, M_STOPPED
	} mode_t;

	// Outcome of handling a byte from the idle mode.
	typedef struct packed {
		logic  emit;
		res_t  res;
		mode_t mode;
		logic  cons;
	} idle_t;

	function automatic idle_t idle_step(input logic [7:0] b);
		idle_t o;
		o.emit = 1'b0;
		o.res  = op_res(K_EOF);
		o.mode = M_IDLE;
		o.cons = 1'b1;
		if (is_alpha(b)) begin
			o.emit = 1'b1;
			o.res  = text_res(K_ID, b);
			o.mode = M_ID;
		end else if (is_digit(b)) begin
			o.emit = 1'b1;
			o.res  = text_res(K_NUM, b);
			o.mode = M_NUM;
		end else begin
			case (b)
				CH_SPACE, CH_NL, CH_TAB: o.mode = M_IDLE;
				CH_QUOTE:  o.mode = M_STR;
				CH_HASH:   o.mode = M_COMMENT;
				CH_EQ:     o.mode = M_EQ;
				CH_BANG:   o.mode = M_BANG;
				CH_GT:     o.mode = M_GT;
				CH_LT:     o.mode = M_LT;
				CH_POPEN: begin
					o.emit = 1'b1;
					o.res  = op_res(K_POPEN);
				end
				CH_PCLOSE: begin
					o.emit = 1'b1;
					o.res  = op_res(K_PCLOSE);
				end
				CH_SOPEN: begin
					o.emit = 1'b1;
					o.res  = op_res(K_SOPEN);
				end
				CH_SCLOSE: begin
					o.emit = 1'b1;
					o.res  = op_res(K_SCLOSE);
				end
				CH_MINUS: begin
					o.emit = 1'b1;
					o.res  = op_res(K_MINUS);
				end
				CH_PLUS: begin
					o.emit = 1'b1;
					o.res  = op_res(K_PLUS);
				end
				CH_STAR: begin
					o.emit = 1'b1;
					o.res  = op_res(K_MUL);
				end
				CH_SLASH: begin
					o.emit = 1'b1;
					o.res  = op_res(K_DIV);
				end
				default: begin
					// Unknown byte: end token, stop, and the byte is not counted.
					o.emit = 1'b1;
					o.res  = op_res(K_EOF);
					o.mode = M_STOPPED;
					o.cons = 1'b0;
				end
			endcase
		end
		return o;
	endfunction

	localparam logic [LINE_BITS-1:0]   LINE_MAX = {LINE_BITS{1'b1}};
	localparam logic [COLUMN_BITS-1:0] COL_MAX  = {COLUMN_BITS{1'b1}};

	logic                   valid_s1;
	logic [7:0]             byte_s1;
	logic                   eoi_s1;
	mode_t                  mode_q;
	mode_t                  mode_d;
	logic [LINE_BITS-1:0]   line_q;
	logic [COLUMN_BITS-1:0] col_q;
	entry_t                 fifo_q [FIFO_DEPTH];
	logic [PTR_BITS-1:0]    wr_q;
	logic [PTR_BITS-1:0]    rd_q;
	logic [CNT_BITS-1:0]    count_q;
	logic                   fire_s1;
	logic                   pop;
	logic                   cons;
	logic                   v0;
	logic                   v1;
	res_t                   r0;
	res_t                   r1;
	idle_t                  ib;
	entry_t                 e0;
	entry_t                 e1;
	entry_t                 head;
	logic [1:0]             push_n;

	// The scan stage fires when the queue can take two more words.
	assign fire_s1  = valid_s1 && (count_q <= CNT_BITS'(FIFO_DEPTH - 2));
	assign in_stall = valid_s1 && !fire_s1;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (fire_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= char_byte;
			eoi_s1  <= end_of_input;
		end
	end

	// Scan logic: next mode, whether the byte is counted, and up to two result words.
	always_comb begin
		r0     = op_res(K_EOF);
		r1     = op_res(K_EOF);
		v0     = 1'b0;
		v1     = 1'b0;
		mode_d = mode_q;
		cons   = 1'b0;
		ib     = idle_step(byte_s1);
		if (eoi_s1) begin
			// Flush a pending token, then the end token unless stopped.
			mode_d = M_IDLE;
			case (mode_q)
				M_ID: begin
					v0 = 1'b1;
					r0 = op_res(K_ID);
				end
				M_NUM, M_NUMDOT: begin
					v0 = 1'b1;
					r0 = op_res(K_NUM);
				end
				M_STR: begin
					v0 = 1'b1;
					r0 = op_res(K_STR);
				end
				M_BANG: begin
					v0 = 1'b1;
					r0 = op_res(K_NOT);
				end
				M_GT: begin
					v0 = 1'b1;
					r0 = op_res(K_GT);
				end
				M_LT: begin
					v0 = 1'b1;
					r0 = op_res(K_LT);
				end
				default: v0 = 1'b0;
			endcase
			if (mode_q != M_STOPPED) begin
				if (v0) begin
					v1 = 1'b1;
					r1 = op_res(K_EOF);
				end else begin
					v0 = 1'b1;
					r0 = op_res(K_EOF);
				end
			end
		end else begin
			case (mode_q)
				M_ID: begin
					if (is_alpha(byte_s1)) begin
						v0   = 1'b1;
						r0   = text_res(K_ID, byte_s1);
						cons = 1'b1;
					end else begin
						v0     = 1'b1;
						r0     = op_res(K_ID);
						v1     = ib.emit;
						r1     = ib.res;
						mode_d = ib.mode;
						cons   = ib.cons;
					end
				end
				M_NUM, M_NUMDOT: begin
					if (is_digit(byte_s1) || (mode_q == M_NUM && byte_s1 == CH_DOT)) begin
						v0   = 1'b1;
						r0   = text_res(K_NUM, byte_s1);
						cons = 1'b1;
						if (byte_s1 == CH_DOT) begin
							mode_d = M_NUMDOT;
						end
					end else begin
						v0     = 1'b1;
						r0     = op_res(K_NUM);
						v1     = ib.emit;
						r1     = ib.res;
						mode_d = ib.mode;
						cons   = ib.cons;
					end
				end
				M_STR: begin
					v0   = 1'b1;
					cons = 1'b1;
					if (byte_s1 == CH_QUOTE) begin
						r0     = op_res(K_STR);
						mode_d = M_IDLE;
					end else begin
						r0 = text_res(K_STR, byte_s1);
					end
				end
				M_COMMENT: begin
					cons = 1'b1;
					if (byte_s1 == CH_NL || byte_s1 == CH_HASH) begin
						mode_d = M_IDLE;
					end
				end
				M_EQ: begin
					if (byte_s1 == CH_GT || byte_s1 == CH_EQ) begin
						v0     = 1'b1;
						r0     = op_res((byte_s1 == CH_GT) ? K_ARROW : K_EQEQ);
						mode_d = M_IDLE;
						cons   = 1'b1;
					end else begin
						v0     = ib.emit;
						r0     = ib.res;
						mode_d = ib.mode;
						cons   = ib.cons;
					end
				end
				M_BANG, M_GT, M_LT: begin
					v0 = 1'b1;
					if (byte_s1 == CH_EQ) begin
						r0     = op_res((mode_q == M_BANG) ? K_NEQ :
						                ((mode_q == M_GT) ? K_GE : K_LE));
						mode_d = M_IDLE;
						cons   = 1'b1;
					end else begin
						r0     = op_res((mode_q == M_BANG) ? K_NOT :
						                ((mode_q == M_GT) ? K_GT : K_LT));
						v1     = ib.emit;
						r1     = ib.res;
						mode_d = ib.mode;
						cons   = ib.cons;
					end
				end
				M_STOPPED: mode_d = M_STOPPED;
				default: begin
					v0     = ib.emit;
					r0     = ib.res;
					mode_d = ib.mode;
					cons   = ib.cons;
				end
			endcase
		end
	end

	// Both words of one input carry the position before the byte is counted.
	always_comb begin
		e0.res  = r0;
		e0.line = POS_BITS'(line_q);
		e0.col  = POS_BITS'(col_q);
		e1.res  = r1;
		e1.line = POS_BITS'(line_q);
		e1.col  = POS_BITS'(col_q);
		push_n  = fire_s1 ? ({1'b0, v0} + {1'b0, v1}) : 2'd0;
	end

	// Scan mode and position counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE;
			line_q <= '0;
			col_q  <= '0;
		end else if (fire_s1) begin
			if (eoi_s1) begin
				mode_q <= M_IDLE;
				line_q <= '0;
				col_q  <= '0;
			end else begin
				mode_q <= mode_d;
				if (cons) begin
					if (byte_s1 == CH_NL) begin
						if (line_q != LINE_MAX) begin
							line_q <= line_q + LINE_BITS'(1);
						end
						col_q <= '0;
					end else if (col_q != COL_MAX) begin
						col_q <= col_q + COLUMN_BITS'(1);
					end
				end
			end
		end
	end

	// Result queue storage.
	always_ff @(posedge clk) begin
		if (fire_s1 && v0) begin
			fifo_q[wr_q] <= e0;
		end
		if (fire_s1 && v1) begin
			fifo_q[wr_q + PTR_BITS'(1)] <= e1;
		end
	end

	assign out_valid = (count_q != '0);
	assign pop       = out_valid && !out_stall;

	// Result queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + PTR_BITS'(push_n);
			rd_q    <= rd_q + PTR_BITS'(pop);
			count_q <= count_q + CNT_BITS'(push_n) - CNT_BITS'(pop);
		end
	end

	assign head          = fifo_q[rd_q];
	assign token_kind    = head.res.kind;
	assign has_byte      = head.res.has;
	assign text_byte     = head.res.text;
	assign token_end     = head.res.fin;
	assign line_number   = head.line;
	assign column_number = head.col;

	// The queue never holds more words than it has entries.
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_BITS'(FIFO_DEPTH))
	else $error("result queue overflow");

	// Input is held back only while a word waits in the scan stage.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1)
	else $error("stall without a pending word");

	// A stopped scanner emits nothing for ordinary bytes.
	assert property (@(posedge clk) disable iff (!arst_n)
		(fire_s1 && !eoi_s1 && mode_q == M_STOPPED) |-> (push_n == 2'd0))
	else $error("result emitted while stopped");

	// End of input returns the scanner and counters to their reset state.
	assert property (@(posedge clk) disable iff (!arst_n)
		(fire_s1 && eoi_s1) |=> (mode_q == M_IDLE && line_q == '0 && col_q == '0))
	else $error("state not cleared after end of input");

endmodule
